// ----- hw/rtl/smpq_pkg.sv -----
// types and constants shared by the sorted minimum priority queue
// no dependencies
`default_nettype none

package smpq_pkg;

    localparam int CAPACITY = 8;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    // counter keeps at least the four bits the result reports
    localparam int CNT_W    = (OCC_W > 4) ? OCC_W : 4;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // operation broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_value value;
    } t_op;

    typedef struct packed {
        logic   occ;
        t_value value;
    } t_slot;

    // what a cell shows its right neighbor
    typedef struct packed {
        logic  keep;
        t_slot slot;
    } t_link;

endpackage

`default_nettype wire

// ----- hw/rtl/smpq_if.sv -----
// valid/ready channels for requests and results of the priority queue
// depends on smpq_pkg
`default_nettype none

interface smpq_req_if;
    import smpq_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_value value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface smpq_rsp_if;
    import smpq_pkg::*;

    logic          valid;
    logic          ready;
    logic          ok;
    t_status       status;
    t_value        head_value;
    logic          head_valid;
    logic [3:0]    count;

    modport source (output valid, output ok, output status, output head_value,
                    output head_valid, output count, input ready);
    modport sink   (input valid, input ok, input status, input head_value,
                    input head_valid, input count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smpq_cell.sv -----
// one slot of the sorted chain: holds a value, shifts right on insert, left on removal
// depends on smpq_pkg
`default_nettype none

module smpq_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire smpq_pkg::t_op   i_op,
    input  wire smpq_pkg::t_link i_left,
    input  wire smpq_pkg::t_slot i_right,
    output smpq_pkg::t_link    o_link,
    output smpq_pkg::t_slot    o_next
);
    import smpq_pkg::*;

    logic   r_occ;
    t_value r_value;
    logic   w_keep;
    logic   n_occ;
    t_value n_value;

    // entry stays in place when it is strictly smaller than the new value
    assign w_keep = r_occ && (r_value < i_op.value);

    always_comb begin
        n_occ   = r_occ;
        n_value = r_value;
        if (i_op.enq) begin
            if (!w_keep) begin
                if (i_left.keep) begin
                    n_occ   = 1'b1;
                    n_value = i_op.value;
                end else begin
                    n_occ   = i_left.slot.occ;
                    n_value = i_left.slot.value;
                end
            end
        end else if (i_op.deq) begin
            n_occ   = i_right.occ;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.keep       = w_keep;
    assign o_link.slot.occ   = r_occ;
    assign o_link.slot.value = r_value;
    assign o_next.occ        = n_occ;
    assign o_next.value      = n_value;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_min_priority_queue.sv -----
// Bounded minimum priority queue built as a chain of CAPACITY cells kept in
// ascending order. Every cell compares its entry with the new value at once,
// so an insert or a removal finishes in the cycle it is accepted and its
// result item appears in the output register on the next cycle. One request
// item is taken per cycle while the result register is empty or being read
// in the same cycle; a stalled result holds further requests back.
// Depends on smpq_pkg, smpq_if and smpq_cell.
`default_nettype none

module sorted_min_priority_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    smpq_req_if.sink    i_req,
    smpq_rsp_if.source  o_rsp
);
    import smpq_pkg::*;

    t_op                 w_op;
    t_link               w_link [CAPACITY];
    t_slot               w_next [CAPACITY];
    logic [CAPACITY-1:0] w_occ;
    logic                w_acc;
    logic                w_full;
    logic                w_empty;

    t_count  r_count;
    t_count  n_count;
    t_status n_status;

    logic    r_rsp_valid;
    logic    r_ok;
    t_status r_status;
    t_value  r_head_value;
    logic    r_head_valid;
    t_count  r_rsp_count;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = w_occ[CAPACITY-1];
    assign w_empty     = !w_occ[0];

    assign w_op.enq   = w_acc && (i_req.kind == KIND_ENQ) && !w_full;
    assign w_op.deq   = w_acc && (i_req.kind == KIND_DEQ) && !w_empty;
    assign w_op.value = i_req.value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link w_left;
        t_slot w_right;

        if (g == 0) begin : g_first
            assign w_left = '{keep: 1'b1, slot: '{occ: 1'b1, value: '0}};
        end else begin : g_mid
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '{occ: 1'b0, value: '0};
        end else begin : g_inner
            assign w_right = w_link[g+1].slot;
        end

        smpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g]),
            .o_next  (w_next[g])
        );

        assign w_occ[g] = w_link[g].slot.occ;
    end

    always_comb begin
        n_count = r_count;
        if (w_op.enq) begin
            n_count = r_count + t_count'(1);
        end else if (w_op.deq) begin
            n_count = r_count - t_count'(1);
        end
    end

    always_comb begin
        n_status = ST_DONE;
        case (i_req.kind)
            KIND_ENQ: if (w_full)  n_status = ST_FULL;
            KIND_DEQ: if (w_empty) n_status = ST_EMPTY;
            default:  n_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok         <= w_op.enq || w_op.deq;
            r_status     <= n_status;
            r_head_valid <= w_next[0].occ;
            r_head_value <= w_next[0].occ ? w_next[0].value : '0;
            r_rsp_count  <= n_count;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.ok         = r_ok;
    assign o_rsp.status     = r_status;
    assign o_rsp.head_value = r_head_value;
    assign o_rsp.head_valid = r_head_valid;
    assign o_rsp.count      = r_rsp_count[3:0];

`ifndef SYNTHESIS
    // entry count tracks the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == t_count'($countones(w_occ)))
        else $error("count differs from occupied cells");

    // occupied cells form an unbroken run from the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ & (w_occ + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
        else $error("gap in occupied cells");

    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.kind == KIND_DEQ) && w_empty)
        |=> (o_rsp.valid && (o_rsp.status == ST_EMPTY) && !o_rsp.ok))
        else $error("removal from empty queue not refused");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ[1] |-> (w_link[0].slot.value <= w_link[1].slot.value)))
        else $error("head is not the smallest entry");
`endif

endmodule

`default_nettype wire

// ----- verif/sorted_min_priority_queue_tb.sv -----
// self-checking testbench for the sorted minimum priority queue
// runs directed corner items, then biased random traffic with random idling
// depends on smpq_pkg, smpq_if and sorted_min_priority_queue
`timescale 1ns / 100ps

module sorted_min_priority_queue_tb;
    import smpq_pkg::*;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int CALM_ITEMS    = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTS    = 30;

    typedef struct packed {
        logic       ok;
        t_status    status;
        t_value     head_value;
        logic       head_valid;
        logic [3:0] count;
    } t_outcome;

    typedef struct packed {
        t_kind    kind;
        t_value   value;
        logic     fixed;
        t_outcome outcome;
    } t_vector;

    localparam t_value   VAL_MIN    = 32'sh8000_0000;
    localparam t_value   VAL_MAX    = 32'sh7FFF_FFFF;
    localparam t_outcome FROM_MODEL = '0;
    localparam int       NUM_ROWS   = 24;

    // fixed rows: empty after reset, extremes, full and empty refusals
    localparam t_vector DIRECTED_ROWS [NUM_ROWS] = '{
        '{KIND_DEQ, 32'sd0,           1'b1, '{1'b0, ST_EMPTY, 32'sd0, 1'b0, 4'd0}},
        '{KIND_ENQ, VAL_MAX,          1'b1, '{1'b1, ST_DONE, VAL_MAX, 1'b1, 4'd1}},
        '{KIND_ENQ, VAL_MIN,          1'b1, '{1'b1, ST_DONE, VAL_MIN, 1'b1, 4'd2}},
        '{KIND_ENQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_ENQ, -32'sd1,          1'b0, FROM_MODEL},
        '{KIND_ENQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_ENQ, VAL_MAX,          1'b0, FROM_MODEL},
        '{KIND_ENQ, 32'sd5,           1'b0, FROM_MODEL},
        '{KIND_ENQ, VAL_MIN,          1'b1, '{1'b1, ST_DONE, VAL_MIN, 1'b1, 4'd8}},
        '{KIND_ENQ, 32'sd3,           1'b1, '{1'b0, ST_FULL, VAL_MIN, 1'b1, 4'd8}},
        '{KIND_ENQ, VAL_MIN,          1'b1, '{1'b0, ST_FULL, VAL_MIN, 1'b1, 4'd8}},
        '{KIND_DEQ, -32'sd1,          1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_DEQ, VAL_MAX,          1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_DEQ, VAL_MIN,          1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sd0,           1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sd0,           1'b1, '{1'b1, ST_DONE, 32'sd0, 1'b0, 4'd0}},
        '{KIND_DEQ, -32'sd1,          1'b1, '{1'b0, ST_EMPTY, 32'sd0, 1'b0, 4'd0}},
        '{KIND_ENQ, 32'sh5555_5555,   1'b0, FROM_MODEL},
        '{KIND_ENQ, 32'shAAAA_AAAA,   1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'sh5555_5555,   1'b0, FROM_MODEL},
        '{KIND_DEQ, 32'shAAAA_AAAA,   1'b0, FROM_MODEL}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    smpq_req_if req_ch ();
    smpq_rsp_if rsp_ch ();

    sorted_min_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_value   sorted_entries [$];
    t_outcome pending_outcomes [$];

    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int n_inserted = 0;
    int n_removed = 0;
    int n_full = 0;
    int n_empty = 0;
    int deepest = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // insert ahead of larger entries, remove from the front
    function automatic t_outcome apply_request(t_kind kind, t_value value);
        t_outcome r;
        int pos;
        r.ok = 1'b0;
        r.status = ST_DONE;
        if (kind == KIND_ENQ) begin
            if (sorted_entries.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos] < value) pos++;
                sorted_entries.insert(pos, value);
                r.ok = 1'b1;
            end
        end else begin
            if (sorted_entries.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                void'(sorted_entries.pop_front());
                r.ok = 1'b1;
            end
        end
        r.head_valid = (sorted_entries.size() != 0);
        r.head_value = r.head_valid ? sorted_entries[0] : '0;
        r.count = 4'(sorted_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
        end
        mismatches++;
    endtask

    task automatic check_result();
        t_outcome want;
        if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected item", 32'(rsp_ch.count), 32'd0);
        end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.ok !== want.ok)
                report_mismatch("ok", 32'(rsp_ch.ok), 32'(want.ok));
            if (rsp_ch.status !== want.status)
                report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.head_value !== want.head_value)
                report_mismatch("head_value", rsp_ch.head_value, want.head_value);
            if (rsp_ch.head_valid !== want.head_valid)
                report_mismatch("head_valid", 32'(rsp_ch.head_valid), 32'(want.head_valid));
            if (rsp_ch.count !== want.count)
                report_mismatch("count", 32'(rsp_ch.count), 32'(want.count));
        end
        results_seen++;
    endtask

    // result side checker and no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) check_result();
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("sorted_min_priority_queue: mismatch");
                $finish;
            end
        end
    end

    // result back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_request(input t_kind kind, input t_value value,
                                input logic fixed, input t_outcome typed);
        t_outcome predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            req_ch.kind  <= t_kind'($urandom_range(0, 1));
            req_ch.value <= t_value'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_request(kind, value);
        pending_outcomes.push_back(fixed ? typed : predicted);
        if (predicted.status == ST_FULL) n_full++;
        else if (predicted.status == ST_EMPTY) n_empty++;
        else if (kind == KIND_ENQ) n_inserted++;
        else n_removed++;
        if (sorted_entries.size() > deepest) deepest = sorted_entries.size();
    endtask

    // hold requests back until every outstanding result has come
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return t_value'($urandom_range(0, 8)) - 32'sd4;
            default: return t_value'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int run_len;
        int enq_pct;
        t_kind kind;

        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_ENQ;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on = 1'b1;
        stalls_on = 1'b1;
        foreach (DIRECTED_ROWS[i]) begin
            send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
                         DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].outcome);
        end
        drain_results();

        // runs biased toward filling, draining or churning keep both ends busy
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 20;
                default: enq_pct = 50;
            endcase
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                kind = ($urandom_range(1, 100) <= enq_pct) ? KIND_ENQ : KIND_DEQ;
                send_request(kind, pick_value(), 1'b0, FROM_MODEL);
                sent++;
            end
            // no pauses once the calm tail has started
            if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d results checked: %0d inserts, %0d removals, %0d full and %0d empty refusals",
                 results_seen, n_inserted, n_removed, n_full, n_empty);
        $display("deepest occupancy %0d of %0d, %0d mismatches", deepest, CAPACITY, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("sorted_min_priority_queue: match");
        end else begin
            $display("sorted_min_priority_queue: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_if.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue.sv
verif/sorted_min_priority_queue_tb.sv
